### hw/rtl/scf_pkg.sv
package scf_pkg;

    // Command codes carried on the opcode field.
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_SET_TARGET = 3'd1,
        OP_ENABLE     = 3'd2,
        OP_DISABLE    = 3'd3,
        OP_INIT       = 3'd4
    } t_opcode;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERVO_ID       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_LIMIT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_DIVIDER   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_COUNT    = 8'd3;

    // Reset values of configuration and command state.
    localparam logic [7:0]  RST_SERVO_ID       = 8'd1;
    localparam logic [15:0] RST_POSITION_LIMIT = 16'd4095;
    localparam logic [7:0]  RST_TICK_DIVIDER   = 8'd2;
    localparam logic [3:0]  RST_RETRY_COUNT    = 4'd3;
    localparam logic [15:0] RST_TARGET_POS     = 16'd2048;

    // Packet bytes.
    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] LEN_BYTE_WR = 8'h04;
    localparam logic [7:0] LEN_MOVE    = 8'h09;
    localparam logic [7:0] INSTR_WRITE = 8'h03;
    localparam logic [7:0] ADDR_TORQUE = 8'h28;
    localparam logic [7:0] ADDR_ACCEL  = 8'h29;
    localparam logic [7:0] ADDR_GOAL   = 8'h2A;

    // Byte positions inside a packet.
    localparam logic [3:0] IDX_BODY_FIRST = 4'd2;
    localparam logic [3:0] IDX_BW_LAST    = 4'd7;
    localparam logic [3:0] IDX_MOVE_LAST  = 4'd12;

    // Packet segments of an init job.
    localparam logic [1:0] SEG_ACCEL  = 2'd0;
    localparam logic [1:0] SEG_MOVE   = 2'd1;
    localparam logic [1:0] SEG_TORQUE = 2'd2;

    // Job queue geometry.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Kinds of packet job handed from the front to the back.
    typedef enum logic [1:0] {
        JOB_TORQUE = 2'd0,
        JOB_MOVE   = 2'd1,
        JOB_INIT   = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic        torque_on;
        logic [15:0] pos;
        logic [15:0] spd;
    } t_job;

    // Byte sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_back_state;

endpackage

### hw/rtl/scf_front.sv
module scf_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [scf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            i_accept,
    input  logic [2:0]                      i_opcode,
    input  logic [15:0]                     i_position,
    input  logic [15:0]                     i_speed,
    output logic                            o_job_valid,
    output scf_pkg::t_job                   o_job,
    output logic [7:0]                      o_servo_id
);

    logic [7:0]  r_servo_id;
    logic [15:0] r_position_limit;
    logic [7:0]  r_tick_divider;
    logic [3:0]  r_retry_count;

    logic [15:0] r_target_pos,  n_target_pos;
    logic [15:0] r_target_spd,  n_target_spd;
    logic [7:0]  r_tick_count,  n_tick_count;
    logic [3:0]  r_retries,     n_retries;
    logic        r_enabled,     n_enabled;

    logic [15:0] clamp_in;
    logic [15:0] clamp_tgt;
    logic [7:0]  tick_inc;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_id       <= scf_pkg::RST_SERVO_ID;
            r_position_limit <= scf_pkg::RST_POSITION_LIMIT;
            r_tick_divider   <= scf_pkg::RST_TICK_DIVIDER;
            r_retry_count    <= scf_pkg::RST_RETRY_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                scf_pkg::CFG_SERVO_ID:       r_servo_id       <= i_cfg_data[7:0];
                scf_pkg::CFG_POSITION_LIMIT: r_position_limit <= i_cfg_data;
                scf_pkg::CFG_TICK_DIVIDER:   r_tick_divider   <= i_cfg_data[7:0];
                scf_pkg::CFG_RETRY_COUNT:    r_retry_count    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Goal positions are clamped to the current limit.
    assign clamp_in  = (i_position > r_position_limit) ? r_position_limit : i_position;
    assign clamp_tgt = (r_target_pos > r_position_limit) ? r_position_limit : r_target_pos;
    assign tick_inc  = r_tick_count + 8'd1;

    // Command decode: update the servo state and classify the packet job.
    always_comb begin
        n_target_pos = r_target_pos;
        n_target_spd = r_target_spd;
        n_tick_count = r_tick_count;
        n_retries    = r_retries;
        n_enabled    = r_enabled;
        o_job_valid  = 1'b0;
        o_job.kind      = scf_pkg::JOB_MOVE;
        o_job.torque_on = 1'b0;
        o_job.pos       = clamp_tgt;
        o_job.spd       = r_target_spd;
        if (i_accept) begin
            case (i_opcode)
                scf_pkg::OP_TICK: begin
                    if (r_enabled) begin
                        if (tick_inc < r_tick_divider) begin
                            n_tick_count = tick_inc;
                        end else begin
                            n_tick_count = '0;
                            o_job_valid  = 1'b1;
                            if (r_retries != 4'd0) begin
                                o_job.kind      = scf_pkg::JOB_TORQUE;
                                o_job.torque_on = 1'b1;
                                n_retries       = r_retries - 4'd1;
                            end
                        end
                    end
                end
                scf_pkg::OP_SET_TARGET: begin
                    n_target_pos = clamp_in;
                    n_target_spd = i_speed;
                end
                scf_pkg::OP_ENABLE: begin
                    n_enabled    = 1'b1;
                    n_tick_count = '0;
                    n_retries    = r_retry_count;
                    o_job_valid  = 1'b1;
                end
                scf_pkg::OP_DISABLE: begin
                    n_enabled    = 1'b0;
                    n_tick_count = '0;
                    n_retries    = '0;
                    o_job_valid  = 1'b1;
                    o_job.kind   = scf_pkg::JOB_TORQUE;
                end
                scf_pkg::OP_INIT: begin
                    n_target_pos = clamp_in;
                    n_target_spd = i_speed;
                    n_tick_count = '0;
                    n_retries    = (r_retry_count != 4'd0) ? r_retry_count - 4'd1 : 4'd0;
                    n_enabled    = 1'b1;
                    o_job_valid  = 1'b1;
                    o_job.kind   = scf_pkg::JOB_INIT;
                    o_job.pos    = clamp_in;
                    o_job.spd    = i_speed;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pos <= scf_pkg::RST_TARGET_POS;
            r_target_spd <= '0;
            r_tick_count <= '0;
            r_retries    <= '0;
            r_enabled    <= 1'b1;
        end else begin
            r_target_pos <= n_target_pos;
            r_target_spd <= n_target_spd;
            r_tick_count <= n_tick_count;
            r_retries    <= n_retries;
            r_enabled    <= n_enabled;
        end
    end

    assign o_servo_id = r_servo_id;

    // A disabled servo has no pending retries and no partial tick count.
    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enabled |-> (r_retries == 4'd0 && r_tick_count == 8'd0))
        else $error("disabled state holds retries or tick count");

endmodule

### hw/rtl/scf_job_queue.sv
module scf_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  scf_pkg::t_job i_wr_data,
    input  logic          i_rd,
    output scf_pkg::t_job o_rd_data,
    output logic          o_full,
    output logic          o_empty
);

    scf_pkg::t_job                r_mem [scf_pkg::QUEUE_DEPTH];
    logic [scf_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [scf_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [scf_pkg::QUEUE_AW:0]   r_count;

    localparam logic [scf_pkg::QUEUE_AW:0] DEPTH_CNT = (scf_pkg::QUEUE_AW+1)'(scf_pkg::QUEUE_DEPTH);

    assign o_full    = (r_count == DEPTH_CNT);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The pointers always sit the fill count apart.
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= DEPTH_CNT) &&
        ((r_wr_ptr - r_rd_ptr) == r_count[scf_pkg::QUEUE_AW-1:0]))
        else $error("job queue pointers disagree with fill count");

endmodule

### hw/rtl/scf_back.sv
module scf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  scf_pkg::t_job i_job,
    input  logic [7:0]    i_servo_id,
    output logic          o_job_take,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_tx_byte,
    output logic          o_last
);

    scf_pkg::t_back_state r_state, n_state;
    scf_pkg::t_job        r_job,   n_job;
    logic [1:0]           r_seg,   n_seg;
    logic [3:0]           r_idx,   n_idx;
    logic [7:0]           r_sum,   n_sum;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_byte,  n_out_byte;
    logic                 r_out_last,  n_out_last;

    logic       is_init;
    logic       is_move;
    logic [3:0] last_idx;
    logic [1:0] last_seg;
    logic [7:0] bw_addr;
    logic [7:0] bw_data;
    logic [7:0] body_byte;
    logic [7:0] cur_byte;
    logic       adv;

    // Packet shape of the current segment.
    assign is_init  = (r_job.kind == scf_pkg::JOB_INIT);
    assign is_move  = (r_job.kind == scf_pkg::JOB_MOVE) ||
                      (is_init && r_seg == scf_pkg::SEG_MOVE);
    assign last_idx = is_move ? scf_pkg::IDX_MOVE_LAST : scf_pkg::IDX_BW_LAST;
    assign last_seg = is_init ? scf_pkg::SEG_TORQUE : scf_pkg::SEG_ACCEL;
    assign bw_addr  = (is_init && r_seg == scf_pkg::SEG_ACCEL) ?
                      scf_pkg::ADDR_ACCEL : scf_pkg::ADDR_TORQUE;
    assign bw_data  = (is_init && r_seg == scf_pkg::SEG_ACCEL) ? 8'd0 :
                      (is_init ? 8'd1 : {7'd0, r_job.torque_on});

    // Byte at the current packet position.
    always_comb begin
        case (r_idx)
            4'd0, 4'd1: body_byte = scf_pkg::SYNC_BYTE;
            4'd2:       body_byte = i_servo_id;
            4'd3:       body_byte = is_move ? scf_pkg::LEN_MOVE : scf_pkg::LEN_BYTE_WR;
            4'd4:       body_byte = scf_pkg::INSTR_WRITE;
            4'd5:       body_byte = is_move ? scf_pkg::ADDR_GOAL : bw_addr;
            4'd6:       body_byte = is_move ? r_job.pos[7:0] : bw_data;
            4'd7:       body_byte = r_job.pos[15:8];
            4'd10:      body_byte = r_job.spd[7:0];
            4'd11:      body_byte = r_job.spd[15:8];
            default:    body_byte = 8'd0;
        endcase
    end

    assign cur_byte = (r_idx == last_idx) ? ~r_sum : body_byte;
    assign adv      = !r_out_valid || i_pop;

    // Sequencer: take a job, then step through its bytes one per beat.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_seg       = r_seg;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !i_pop;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_job_take  = 1'b0;
        case (r_state)
            scf_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_take = 1'b1;
                    n_job      = i_job;
                    n_seg      = scf_pkg::SEG_ACCEL;
                    n_idx      = '0;
                    n_sum      = '0;
                    n_state    = scf_pkg::ST_SEND;
                end
            end
            scf_pkg::ST_SEND: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = cur_byte;
                    n_out_last  = 1'b0;
                    if (r_idx == last_idx) begin
                        n_idx = '0;
                        n_sum = '0;
                        if (r_seg == last_seg) begin
                            n_out_last = 1'b1;
                            n_state    = scf_pkg::ST_IDLE;
                        end else begin
                            n_seg = r_seg + 2'd1;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                        if (r_idx >= scf_pkg::IDX_BODY_FIRST) begin
                            n_sum = r_sum + body_byte;
                        end
                    end
                end
            end
            default: n_state = scf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scf_pkg::ST_IDLE;
            r_seg       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seg       <= n_seg;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_sum      <= n_sum;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_empty   = !r_out_valid;
    assign o_tx_byte = r_out_byte;
    assign o_last    = r_out_last;

    // The byte index never runs past the end of the current packet.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scf_pkg::ST_SEND) |-> (r_idx <= last_idx))
        else $error("byte index beyond packet end");

    // The segment never runs past the last packet of the job.
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scf_pkg::ST_SEND) |-> (r_seg <= last_seg))
        else $error("segment beyond last packet of job");

    // A finished job leaves a final byte waiting on the output.
    a_last_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scf_pkg::ST_SEND && n_state == scf_pkg::ST_IDLE) |=>
        (r_out_valid && r_out_last))
        else $error("job ended without a final byte");

endmodule

### hw/rtl/servo_command_frame_scheduler.sv
// Serial-bus servo packet generator. Commands (tick, set_target, enable,
// disable, init) enter through a push/full queue port; one command is taken
// per clock while the four-entry job queue between the command decoder and
// the byte sequencer has room. The byte sequencer emits one packet byte per
// clock on a pop/empty queue port, except while an unpopped byte holds its
// output: a torque packet is 8 bytes, a move packet 13 and an init sequence
// 29, and the sequencer picks up each job in its idle state before sending.
// The last byte a command produces is flagged with o_last. Configuration
// writes are taken at any time on the cfg channel and are meant to be made
// while no packet is pending.
module servo_command_frame_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [scf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [2:0]                      i_opcode,
    input  logic [15:0]                     i_position,
    input  logic [15:0]                     i_speed,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_tx_byte,
    output logic                            o_last
);

    logic          accept;
    logic          job_valid;
    scf_pkg::t_job job_in;
    scf_pkg::t_job job_out;
    logic          q_empty;
    logic          job_take;
    logic [7:0]    servo_id;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // Command decoder and configuration registers.
    scf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_speed     (i_speed),
        .o_job_valid (job_valid),
        .o_job       (job_in),
        .o_servo_id  (servo_id)
    );

    // Packet jobs waiting for the sequencer.
    scf_job_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (job_valid),
        .i_wr_data (job_in),
        .i_rd      (job_take),
        .o_rd_data (job_out),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    // Byte sequencer with output register.
    scf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (job_out),
        .i_servo_id  (servo_id),
        .o_job_take  (job_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

endmodule

### test/servo_command_frame_scheduler_tb.sv
module servo_command_frame_scheduler_tb;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 64;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int RANDOM_ITEMS   = 168;
    localparam int RANDOM_PHASES  = 6;
    localparam int MAX_IDLE       = 10;

    // Opcodes outside the command set; the block must ignore them.
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    // Data bytes of the single-byte register writes and the move packet padding.
    localparam logic [7:0] TORQUE_OFF    = 8'd0;
    localparam logic [7:0] TORQUE_ON     = 8'd1;
    localparam logic [7:0] ACCEL_DEFAULT = 8'd0;
    localparam logic [7:0] PAD_BYTE      = 8'd0;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_beat;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [scf_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [15:0]                     i_cfg_data;
    logic                            push;
    logic                            full;
    logic [2:0]                      i_opcode;
    logic [15:0]                     i_position;
    logic [15:0]                     i_speed;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [7:0]                      o_tx_byte;
    logic                            o_last;

    // Shadow copy of the registers and the command state.
    logic [7:0]  cfg_servo_id;
    logic [15:0] cfg_limit;
    logic [7:0]  cfg_divider;
    logic [3:0]  cfg_retries;
    logic [15:0] goal_pos;
    logic [15:0] goal_speed;
    logic [7:0]  tick_cnt;
    logic [3:0]  retries_left;
    logic        torque_enabled;

    // Packet bytes built for the command being predicted.
    logic [7:0] packet_buf [0:31];
    int         packet_len;
    logic [7:0] packet_sum;

    t_beat expected_beats[$];
    int    mismatches = 0;
    bit    no_idle = 1'b0;
    int    pop_hold;

    servo_command_frame_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_speed     (i_speed),
        .empty       (empty),
        .pop         (pop),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int draw_idle();
        return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Packet assembly: sync bytes, body with running sum, inverted checksum.
    function automatic void open_packet();
        packet_buf[packet_len]     = scf_pkg::SYNC_BYTE;
        packet_buf[packet_len + 1] = scf_pkg::SYNC_BYTE;
        packet_len = packet_len + 2;
        packet_sum = 8'd0;
    endfunction

    function automatic void put_body(input logic [7:0] b);
        packet_buf[packet_len] = b;
        packet_len = packet_len + 1;
        packet_sum = packet_sum + b;
    endfunction

    function automatic void close_packet();
        packet_buf[packet_len] = ~packet_sum;
        packet_len = packet_len + 1;
    endfunction

    function automatic logic [15:0] clamp_goal(input logic [15:0] p);
        return (p > cfg_limit) ? cfg_limit : p;
    endfunction

    function automatic void add_byte_write(input logic [7:0] addr, input logic [7:0] val);
        open_packet();
        put_body(cfg_servo_id);
        put_body(scf_pkg::LEN_BYTE_WR);
        put_body(scf_pkg::INSTR_WRITE);
        put_body(addr);
        put_body(val);
        close_packet();
    endfunction

    // The goal is clamped again against the limit in force when it is sent.
    function automatic void add_move();
        logic [15:0] p;
        p = clamp_goal(goal_pos);
        open_packet();
        put_body(cfg_servo_id);
        put_body(scf_pkg::LEN_MOVE);
        put_body(scf_pkg::INSTR_WRITE);
        put_body(scf_pkg::ADDR_GOAL);
        put_body(p[7:0]);
        put_body(p[15:8]);
        put_body(PAD_BYTE);
        put_body(PAD_BYTE);
        put_body(goal_speed[7:0]);
        put_body(goal_speed[15:8]);
        close_packet();
    endfunction

    function automatic void spend_retry();
        if (retries_left != 4'd0) begin
            retries_left = retries_left - 4'd1;
        end
    endfunction

    function automatic void reset_shadow();
        cfg_servo_id   = scf_pkg::RST_SERVO_ID;
        cfg_limit      = scf_pkg::RST_POSITION_LIMIT;
        cfg_divider    = scf_pkg::RST_TICK_DIVIDER;
        cfg_retries    = scf_pkg::RST_RETRY_COUNT;
        goal_pos       = scf_pkg::RST_TARGET_POS;
        goal_speed     = 16'd0;
        tick_cnt       = 8'd0;
        retries_left   = 4'd0;
        torque_enabled = 1'b1;
    endfunction

    // Updates the shadow state for one accepted command and queues its bytes.
    function automatic void predict_packets(input logic [2:0] op, input logic [15:0] pos,
                                            input logic [15:0] spd);
        packet_len = 0;
        case (op)
            scf_pkg::OP_TICK: begin
                if (torque_enabled) begin
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt >= cfg_divider) begin
                        tick_cnt = 8'd0;
                        if (retries_left != 4'd0) begin
                            add_byte_write(scf_pkg::ADDR_TORQUE, TORQUE_ON);
                            spend_retry();
                        end else begin
                            add_move();
                        end
                    end
                end
            end
            scf_pkg::OP_SET_TARGET: begin
                goal_pos   = clamp_goal(pos);
                goal_speed = spd;
            end
            scf_pkg::OP_ENABLE: begin
                torque_enabled = 1'b1;
                tick_cnt       = 8'd0;
                retries_left   = cfg_retries;
                add_move();
            end
            scf_pkg::OP_DISABLE: begin
                torque_enabled = 1'b0;
                tick_cnt       = 8'd0;
                retries_left   = 4'd0;
                add_byte_write(scf_pkg::ADDR_TORQUE, TORQUE_OFF);
            end
            scf_pkg::OP_INIT: begin
                goal_pos       = clamp_goal(pos);
                goal_speed     = spd;
                tick_cnt       = 8'd0;
                retries_left   = cfg_retries;
                torque_enabled = 1'b1;
                add_byte_write(scf_pkg::ADDR_ACCEL, ACCEL_DEFAULT);
                add_move();
                add_byte_write(scf_pkg::ADDR_TORQUE, TORQUE_ON);
                spend_retry();
            end
            default: begin
            end
        endcase
        for (int i = 0; i < packet_len; i++) begin
            expected_beats.push_back('{tx_byte: packet_buf[i], last: (i == packet_len - 1)});
        end
    endfunction

    // Sends one command beat after a random gap; push stays high across
    // back-to-back beats so it is never lowered and raised in one step.
    task automatic send_command(input logic [2:0] op, input logic [15:0] pos,
                                input logic [15:0] spd);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_opcode   <= op;
        i_position <= pos;
        i_speed    <= spd;
        do @(posedge i_clk); while (full);
        predict_packets(op, pos, spd);
    endtask

    // Drains all pending bytes, then lets any byte-less command finish.
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [scf_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            scf_pkg::CFG_SERVO_ID:       cfg_servo_id = value[7:0];
            scf_pkg::CFG_POSITION_LIMIT: cfg_limit    = value;
            scf_pkg::CFG_TICK_DIVIDER:   cfg_divider  = value[7:0];
            scf_pkg::CFG_RETRY_COUNT:    cfg_retries  = value[3:0];
            default: begin
            end
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset settings: divider, retry sequence, clamping, disable, reserved codes and init.
    task automatic test_reset_settings();
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        send_command(scf_pkg::OP_SET_TARGET, 16'hFFFF, 16'hFFFF);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        send_command(scf_pkg::OP_ENABLE, 16'd0, 16'd0);
        repeat (8) send_command(scf_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        send_command(scf_pkg::OP_DISABLE, 16'd0, 16'd0);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        send_command(scf_pkg::OP_SET_TARGET, 16'd0, 16'd0);
        for (int r = OP_RESERVED_LO; r <= OP_RESERVED_HI; r++) begin
            send_command(r[2:0], 16'hFFFF, 16'hFFFF);
        end
        send_command(scf_pkg::OP_INIT, 16'hFFFF, 16'd0);
        send_command(scf_pkg::OP_INIT, 16'd0, 16'hFFFF);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
    endtask

    // Register extremes: divider and retry count of zero, ids 255 and 254.
    task automatic test_register_extremes();
        wait_idle();
        write_register(scf_pkg::CFG_SERVO_ID, 16'd255);
        write_register(scf_pkg::CFG_POSITION_LIMIT, 16'd0);
        write_register(scf_pkg::CFG_TICK_DIVIDER, 16'd0);
        write_register(scf_pkg::CFG_RETRY_COUNT, 16'd0);
        send_command(scf_pkg::OP_INIT, 16'd1234, 16'hA5A5);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        send_command(scf_pkg::OP_ENABLE, 16'd0, 16'd0);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        wait_idle();
        write_register(scf_pkg::CFG_SERVO_ID, 16'd254);
        write_register(scf_pkg::CFG_POSITION_LIMIT, 16'hFFFF);
        write_register(scf_pkg::CFG_TICK_DIVIDER, 16'd1);
        write_register(scf_pkg::CFG_RETRY_COUNT, 16'd15);
        send_command(scf_pkg::OP_INIT, 16'hFFFF, 16'hFFFF);
        repeat (17) send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
    endtask

    // A stored target above a newly lowered limit is clamped when sent.
    task automatic test_limit_lowered();
        wait_idle();
        write_register(scf_pkg::CFG_POSITION_LIMIT, 16'd4095);
        send_command(scf_pkg::OP_SET_TARGET, 16'd3000, 16'h1234);
        wait_idle();
        write_register(scf_pkg::CFG_POSITION_LIMIT, 16'd100);
        send_command(scf_pkg::OP_ENABLE, 16'd0, 16'd0);
        send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
    endtask

    // Largest divider: only the 255th enabled tick sends a packet.
    task automatic test_slow_divider();
        wait_idle();
        write_register(scf_pkg::CFG_SERVO_ID, 16'd0);
        write_register(scf_pkg::CFG_TICK_DIVIDER, 16'd255);
        write_register(scf_pkg::CFG_RETRY_COUNT, 16'd1);
        no_idle = 1'b1;
        send_command(scf_pkg::OP_ENABLE, 16'd0, 16'd0);
        repeat (255) send_command(scf_pkg::OP_TICK, 16'd0, 16'd0);
        no_idle = 1'b0;
    endtask

    task automatic randomize_registers();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0:       v = 16'd0;
            1:       v = 16'd255;
            default: v = 16'($urandom_range(0, 255));
        endcase
        write_register(scf_pkg::CFG_SERVO_ID, v);
        case ($urandom_range(0, 3))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2:       v = 16'($urandom_range(0, 4095));
            default: v = 16'($urandom);
        endcase
        write_register(scf_pkg::CFG_POSITION_LIMIT, v);
        v = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 40)) :
                                          16'($urandom_range(0, 4));
        write_register(scf_pkg::CFG_TICK_DIVIDER, v);
        write_register(scf_pkg::CFG_RETRY_COUNT, 16'($urandom_range(0, 15)));
    endtask

    // Ticks most often, with the enabled path exercised; targets often sit near the limit.
    task automatic send_random_command();
        int          pick;
        logic [2:0]  op;
        logic [15:0] pos;
        logic [15:0] spd;
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = scf_pkg::OP_TICK;
        else if (pick < 60) op = scf_pkg::OP_SET_TARGET;
        else if (pick < 70) op = scf_pkg::OP_ENABLE;
        else if (pick < 77) op = scf_pkg::OP_DISABLE;
        else if (pick < 90) op = scf_pkg::OP_INIT;
        else                op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
        if ($urandom_range(0, 3) == 0) begin
            pos = cfg_limit + 16'($urandom_range(0, 2)) - 16'd1;
        end else begin
            pos = 16'($urandom);
        end
        spd = 16'($urandom);
        send_command(op, pos, spd);
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            randomize_registers();
            for (int k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++) begin
                if (k % 20 == 0) begin
                    no_idle = ($urandom_range(0, 4) == 0);
                end
                send_random_command();
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random pop stalls and a check of every accepted beat.
    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            pop_hold = 0;
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, tx_byte %02h last %0b",
                             $time, o_tx_byte, o_last);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    if (o_tx_byte !== want.tx_byte) begin
                        $display("%0t: tx_byte mismatch, expected %02h, actual %02h",
                                 $time, want.tx_byte, o_tx_byte);
                        mismatches++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch, expected %0b, actual %0b",
                                 $time, want.last, o_last);
                        mismatches++;
                    end
                end
                pop_hold = draw_idle();
            end else if (pop_hold > 0) begin
                pop_hold = pop_hold - 1;
            end
            pop <= (pop_hold == 0);
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= scf_pkg::CFG_SERVO_ID;
        i_cfg_data  <= 16'd0;
        push        <= 1'b0;
        i_opcode    <= scf_pkg::OP_TICK;
        i_position  <= 16'd0;
        i_speed     <= 16'd0;
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_register_extremes();
        test_limit_lowered();
        test_slow_divider();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout", $time);
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/scf_pkg.sv
hw/rtl/scf_front.sv
hw/rtl/scf_job_queue.sv
hw/rtl/scf_back.sv
hw/rtl/servo_command_frame_scheduler.sv
test/servo_command_frame_scheduler_tb.sv
